FILE: design/path_guided_row_leveling_unit_defines.svh
// Assertion macros for the row leveling unit.
`ifndef PATH_GUIDED_ROW_LEVELING_UNIT_DEFINES_SVH
`define PATH_GUIDED_ROW_LEVELING_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PGRL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PGRL_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PGRL_ASSERT(lbl, clk, rstn, prop, msg)
`define PGRL_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: design/pgrl_pkg.sv
package pgrl_pkg;
  localparam int DefMaxWidth    = 1024;
  localparam int DefMaxHeight   = 1024;
  localparam int DefMaxLines    = 18;
  localparam int DefMaxWindow   = 128;
  localparam int DefFracBits    = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THICK  = 2'd2;
  localparam logic [1:0] REG_LINES  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WIN_START,
    ST_WIN_DIV,
    ST_WIN_STORE,
    ST_PIX_RD,
    ST_PIX_WT,
    ST_PIX_ACC,
    ST_MEAN_DIV,
    ST_MEAN_ADD,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch input beat
    logic do_load;     // write line table
    logic win_init;    // start window pass
    logic win_start;   // start division for current line
    logic div_step;    // one divider step
    logic win_store;   // store window, advance line
    logic pix_rd;      // read row buffer, start weight scan
    logic wt_step;     // count one line
    logic pix_acc;     // accumulate, write row buffer, make result
    logic mean_start;  // start mean division
    logic mean_add;    // add mean into correction
    logic drain_emit;  // make drain result, advance counters
    logic out_load;    // load output register
    logic out_take;    // output beat taken
  } pgrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pix_ok;      // pixel item is in range
    logic drain_ok;    // drain item is in range
    logic need_win;    // pixel starts a row with r > 0
    logic has_result;  // pixel in row > 0
    logic row_end;     // pixel closes the row
    logic need_mean;   // row end in a row > 0, with weight
    logic win_done;    // all lines processed
    logic win_active;  // current line takes part
    logic div_done;    // divider finished
    logic wt_done;     // weight scan finished
    logic out_busy;    // output register full and not taken
  } pgrl_sts_t;
endpackage

FILE: design/path_guided_row_leveling_unit.sv
// Channel   | Direction | Handshake           | Payload
// s_axis    | in        | s_tvalid/s_tready   | tuser: command; tdata: line_index, x/y endpoints,
//           |           |                     | sample
// m_axis    | out       | m_tvalid/m_tready   | tdata: corrected_value; tlast: last_of_image
// cfg       | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. A load passes through the load state; a drain reads the row buffer and
// goes to the output state; a pixel reads the row buffer, runs the serial weight scan over
// line_count lines, accumulates and, when it returns a beat, goes to the output state. The
// first pixel of each row past the first adds a pass over all table slots, with a serial
// divide for each active line. After a row's last beat is loaded into the output register,
// a row with weight adds a serial mean divide. Reset clears counters and correction; tables and
// row buffer stay undefined. A stalled output beat holds the controller in its output state.
module path_guided_row_leveling_unit #(
  parameter int MaxWidth  = pgrl_pkg::DefMaxWidth,
  parameter int MaxHeight = pgrl_pkg::DefMaxHeight,
  parameter int MaxLines  = pgrl_pkg::DefMaxLines,
  parameter int MaxWindow = pgrl_pkg::DefMaxWindow,
  parameter int FracBits  = pgrl_pkg::DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] command
  input  logic [1:0]  s_tuser,
  // [4:0] line_index, [14:5] x_start, [24:15] y_start, [34:25] x_end,
  // [44:35] y_end, [60:45] sample, [63:61] zero
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [47:0] corrected_value
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import pgrl_pkg::*;

  pgrl_cmd_t cmd;
  pgrl_sts_t sts;
  logic signed [47:0] val;

  assign cfg_ready = 1'b1;
  assign m_tdata = val;

  pgrl_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i(s_tvalid), .cmd_i(s_tuser),
    .s_tready_o(s_tready), .sts_i(sts), .cmd_o(cmd)
  );

  pgrl_dp #(
    .MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxLines(MaxLines),
    .MaxWindow(MaxWindow), .FracBits(FracBits)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(s_tuser), .line_index_i(s_tdata[4:0]), .x_start_i(s_tdata[14:5]),
    .y_start_i(s_tdata[24:15]), .x_end_i(s_tdata[34:25]), .y_end_i(s_tdata[44:35]),
    .sample_i(s_tdata[60:45]),
    .cfg_we_i(cfg_valid), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .cmd_in_i(cmd), .sts_o(sts),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_value_o(val), .m_last_o(m_tlast)
  );
endmodule

FILE: design/pgrl_ctrl.sv
`include "path_guided_row_leveling_unit_defines.svh"
module pgrl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic [1:0]          cmd_i,
  output logic                s_tready_o,
  input  pgrl_pkg::pgrl_sts_t sts_i,
  output pgrl_pkg::pgrl_cmd_t cmd_o
);
  import pgrl_pkg::*;

  state_e state_q, state_d;
  logic   mean_q, mean_d;
  logic   acc;

  assign acc = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mean_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mean_q  <= mean_d;
    end
  end

  // The row-end mean is folded in only after the row's last beat is loaded into the output
  // register, so that beat still carries the old correction.
  always_comb begin
    state_d = state_q;
    mean_d  = mean_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (cmd_i == CMD_LOAD) state_d = ST_LOAD;
          else if (cmd_i == CMD_PIXEL || cmd_i == CMD_DRAIN) state_d = ST_PIX_RD;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_PIX_RD: begin
        if (!sts_i.pix_ok && !sts_i.drain_ok) state_d = ST_IDLE;
        else if (sts_i.drain_ok) state_d = ST_OUT;
        else if (sts_i.need_win) state_d = ST_WIN_START;
        else state_d = ST_PIX_WT;
      end
      ST_WIN_START: begin
        if (sts_i.win_done) state_d = ST_PIX_WT;
        else if (sts_i.win_active) state_d = ST_WIN_DIV;
        else state_d = ST_WIN_STORE;
      end
      ST_WIN_DIV:   if (sts_i.div_done) state_d = ST_WIN_STORE;
      ST_WIN_STORE: state_d = ST_WIN_START;
      ST_PIX_WT:    if (sts_i.wt_done) state_d = ST_PIX_ACC;
      ST_PIX_ACC: begin
        mean_d = sts_i.need_mean;
        if (sts_i.has_result) state_d = ST_OUT;
        else state_d = ST_IDLE;
      end
      ST_MEAN_DIV:  if (sts_i.div_done) state_d = ST_MEAN_ADD;
      ST_MEAN_ADD: begin
        mean_d = 1'b0;
        state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) state_d = mean_q ? ST_MEAN_DIV : ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.capture = acc;
      end
      ST_LOAD: cmd_o.do_load = 1'b1;
      ST_PIX_RD: begin
        cmd_o.pix_rd = 1'b1;
        cmd_o.win_init = sts_i.pix_ok && sts_i.need_win;
      end
      ST_WIN_START: cmd_o.win_start = !sts_i.win_done && sts_i.win_active;
      ST_WIN_DIV:   cmd_o.div_step = 1'b1;
      ST_WIN_STORE: cmd_o.win_store = 1'b1;
      ST_PIX_WT:    cmd_o.wt_step = 1'b1;
      ST_PIX_ACC: begin
        cmd_o.pix_acc = 1'b1;
        cmd_o.mean_start = sts_i.need_mean;
      end
      ST_MEAN_DIV:  cmd_o.div_step = 1'b1;
      ST_MEAN_ADD:  cmd_o.mean_add = 1'b1;
      ST_OUT: begin
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.drain_emit = !sts_i.out_busy && sts_i.drain_ok;
      end
      default: ;
    endcase
  end

  `PGRL_ASSERT(a_rdy_idle, clk_i, rst_ni, s_tready_o |-> state_q == ST_IDLE,
               "ready outside idle")
  `PGRL_ASSERT(a_load_ret, clk_i, rst_ni, state_q == ST_LOAD |=> state_q == ST_IDLE,
               "load did not return")
  `PGRL_ASSERT(a_out_wait, clk_i, rst_ni,
               (state_q == ST_OUT && sts_i.out_busy) |=> state_q == ST_OUT,
               "left output state while busy")
endmodule

FILE: design/pgrl_dp.sv
`include "path_guided_row_leveling_unit_defines.svh"
module pgrl_dp #(
  parameter int MaxWidth  = pgrl_pkg::DefMaxWidth,
  parameter int MaxHeight = pgrl_pkg::DefMaxHeight,
  parameter int MaxLines  = pgrl_pkg::DefMaxLines,
  parameter int MaxWindow = pgrl_pkg::DefMaxWindow,
  parameter int FracBits  = pgrl_pkg::DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          cmd_i,
  input  logic [4:0]          line_index_i,
  input  logic [9:0]          x_start_i,
  input  logic [9:0]          y_start_i,
  input  logic [9:0]          x_end_i,
  input  logic [9:0]          y_end_i,
  input  logic signed [15:0]  sample_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i,
  input  pgrl_pkg::pgrl_cmd_t cmd_in_i,
  output pgrl_pkg::pgrl_sts_t sts_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic signed [47:0]  m_value_o,
  output logic                m_last_o
);
  import pgrl_pkg::*;

  localparam int CW = $clog2(MaxWidth + 1);
  localparam int CA = $clog2(MaxWidth);
  localparam int HW = $clog2(MaxHeight + 1);
  localparam int LW = $clog2(MaxLines + 1);
  localparam int LA = (MaxLines > 1) ? $clog2(MaxLines) : 1;
  localparam int WW = CW + 2;            // signed window bound
  localparam int WTW = $clog2(MaxLines * MaxWidth + 1) + 1;
  localparam int SW = 17 + LW + CA + 1;  // difference sum
  localparam int NW = SW + FracBits;     // mean numerator
  localparam int DIVW = (NW > 24) ? NW : 24;
  localparam int DVW = (WTW > 22) ? WTW : 22;
  localparam int CNW = $clog2(DIVW + 1);
  localparam logic signed [47:0] SatMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SatMin = {1'b1, {47{1'b0}}};

  // configuration
  logic [10:0] width_q, height_q;
  logic [7:0]  thick_q;
  logic [4:0]  lines_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd1024; height_q <= 11'd1024; thick_q <= 8'd1; lines_q <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_THICK:  thick_q  <= cfg_data_i[7:0];
        REG_LINES:  lines_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [8:0]    t_eff;
  logic [LW-1:0] n_lines;
  always_comb begin
    if (width_q == 11'd0) w_eff = CW'(1);
    else if (32'(width_q) > MaxWidth) w_eff = CW'(MaxWidth);
    else w_eff = CW'(width_q);
    if (height_q == 11'd0) h_eff = HW'(1);
    else if (32'(height_q) > MaxHeight) h_eff = HW'(MaxHeight);
    else h_eff = HW'(height_q);
    if (thick_q == 8'd0) t_eff = 9'd1;
    else if (32'(thick_q) > MaxWindow) t_eff = 9'(MaxWindow);
    else t_eff = {1'b0, thick_q};
    if (32'(lines_q) > MaxLines) n_lines = LW'(MaxLines);
    else n_lines = LW'(lines_q);
  end

  // captured beat
  logic [1:0] cmd_q;
  logic [4:0] idx_q;
  logic [9:0] xa_q, ya_q, xb_q, yb_q;
  logic signed [15:0] s_q;
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.capture) begin
      cmd_q <= cmd_i; idx_q <= line_index_i; s_q <= sample_i;
      xa_q <= x_start_i; ya_q <= y_start_i; xb_q <= x_end_i; yb_q <= y_end_i;
    end
  end

  // line table memory: {xa, ya, xb, yb} each 12 bits
  logic [47:0] ltab [MaxLines];
  logic [47:0] lrd_q;
  logic [LA-1:0] lptr_q, lptr_n;
  logic [LW-1:0] lcnt_q;

  function automatic logic [11:0] clampu(input logic [9:0] v, input logic [11:0] lim);
    clampu = ({2'b0, v} > lim - 12'd1) ? lim - 12'd1 : {2'b0, v};
  endfunction

  logic swap;
  logic [47:0] lwr;
  assign swap = ya_q > yb_q;
  assign lwr = swap ?
    {clampu(xb_q, 12'(w_eff)), clampu(yb_q, 12'(h_eff)),
     clampu(xa_q, 12'(w_eff)), clampu(ya_q, 12'(h_eff))} :
    {clampu(xa_q, 12'(w_eff)), clampu(ya_q, 12'(h_eff)),
     clampu(xb_q, 12'(w_eff)), clampu(yb_q, 12'(h_eff))};

  // read ahead at the pointer of the next cycle so the line is ready on entry
  always_comb begin
    lptr_n = lptr_q;
    if (cmd_in_i.win_init) lptr_n = '0;
    else if (cmd_in_i.win_store && 32'(lcnt_q) < MaxLines - 1) lptr_n = lptr_q + LA'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.do_load && 32'(idx_q) < MaxLines) ltab[LA'(idx_q)] <= lwr;
    lrd_q <= ltab[lptr_n];
  end

  // counters
  logic [HW-1:0] row_q;
  logic [CW-1:0] col_q, drn_q;
  logic signed [SW-1:0] dsum_q;
  logic [WTW-1:0] wsum_q;
  logic signed [47:0] corr_q;

  // windows: lo/hi in WW signed bits
  logic signed [WW-1:0] wlo_q [MaxLines];
  logic signed [WW-1:0] whi_q [MaxLines];

  // shared restoring divider on magnitudes
  logic [DIVW-1:0] dq_q;  // dividend shifting into quotient
  logic [DIVW:0]   rem_q;
  logic [DVW-1:0]  dv_q;
  logic [CNW-1:0]  dcnt_q;
  logic            dneg_q;
  logic [DIVW:0]   rtry;
  assign rtry = {rem_q[DIVW-1:0], dq_q[DIVW-1]} - (DIVW+1)'(dv_q);

  // window line fields
  logic signed [12:0] lxa, lya, lxb, lyb, p, q, rl;
  logic signed [35:0] num;
  assign lxa = {1'b0, lrd_q[47:36]};
  assign lya = {1'b0, lrd_q[35:24]};
  assign lxb = {1'b0, lrd_q[23:12]};
  assign lyb = {1'b0, lrd_q[11:0]};
  assign p = lxb - lxa;
  assign q = lyb - lya;
  assign rl = 13'(row_q);
  assign num = 36'(36'(2 * 36'(rl - lya) + 1) * 36'(p)) + 36'(q);

  logic active;
  assign active = (lcnt_q < n_lines) && (lya < rl) && (rl <= lyb);

  logic signed [DIVW:0] quo_s;
  assign quo_s = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

  logic signed [WW+2:0] xq, lo_v, hi_v, wmax_v;
  assign xq     = (WW+3)'(quo_s) + (WW+3)'(lxa);
  assign lo_v   = xq - (WW+3)'((t_eff - 9'd1) >> 1);
  assign hi_v   = xq + (WW+3)'(t_eff >> 1);
  assign wmax_v = $signed((WW+3)'(w_eff)) - (WW+3)'(1);

  // weight scan
  logic [LA-1:0] wptr_q;
  logic [LW-1:0] wcnt_q;
  logic [LW-1:0] wt_q;
  logic signed [WW-1:0] colv;
  assign colv = WW'(col_q);

  // row buffer memory
  logic signed [15:0] rbuf [MaxWidth];
  logic signed [15:0] prev_q;
  logic [CA-1:0] raddr;
  assign raddr = (cmd_q == CMD_DRAIN) ? drn_q[CA-1:0] : col_q[CA-1:0];
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.pix_rd) prev_q <= rbuf[raddr];
    if (cmd_in_i.pix_acc) rbuf[col_q[CA-1:0]] <= s_q;
  end

  // status
  logic pix_ok, drain_ok, row_end;
  assign pix_ok   = cmd_q == CMD_PIXEL && row_q < h_eff && 32'(col_q) < MaxWidth;
  assign drain_ok = cmd_q == CMD_DRAIN && row_q >= h_eff && 32'(drn_q) < MaxWidth;
  assign row_end  = col_q >= w_eff - CW'(1);

  logic signed [16:0] diff;
  logic signed [SW-1:0] dsum_n;
  logic [WTW-1:0] wsum_n;
  assign diff   = 17'(s_q) - 17'(prev_q);
  assign dsum_n = dsum_q + SW'(diff) * SW'($signed({1'b0, wt_q}));
  assign wsum_n = wsum_q + WTW'(wt_q);

  logic signed [NW-1:0] mnum;
  assign mnum = NW'(dsum_n) <<< FracBits;

  // output
  logic signed [48:0] oval;
  logic signed [47:0] osat;
  assign oval = 49'(48'(prev_q) <<< FracBits) - 49'(corr_q);
  assign osat = (oval > 49'(SatMax)) ? SatMax : (oval < 49'(SatMin)) ? SatMin : 48'(oval);

  logic signed [48:0] csum;
  assign csum = 49'(corr_q) + 49'(quo_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; drn_q <= '0; dsum_q <= '0; wsum_q <= '0;
      corr_q <= '0; m_tvalid_o <= 1'b0; lptr_q <= '0; lcnt_q <= '0;
      wptr_q <= '0; wcnt_q <= '0; wt_q <= '0; dcnt_q <= '0;
    end else begin
      if (cmd_in_i.win_init) begin
        lptr_q <= '0; lcnt_q <= '0;
      end
      if (cmd_in_i.win_start) begin
        dq_q <= DIVW'(num < 0 ? -num : num);
        dneg_q <= num < 0;
        rem_q <= '0; dv_q <= DVW'(2 * 32'(q)); dcnt_q <= CNW'(DIVW);
      end
      if (cmd_in_i.mean_start) begin
        dq_q <= DIVW'(mnum < 0 ? -mnum : mnum);
        dneg_q <= mnum < 0;
        rem_q <= '0; dv_q <= DVW'(wsum_n); dcnt_q <= CNW'(DIVW);
      end
      if (cmd_in_i.div_step && dcnt_q != '0) begin
        dcnt_q <= dcnt_q - CNW'(1);
        if (!rtry[DIVW]) begin
          rem_q <= rtry; dq_q <= {dq_q[DIVW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[DIVW-1:0], dq_q[DIVW-1]}; dq_q <= {dq_q[DIVW-2:0], 1'b0};
        end
      end
      if (cmd_in_i.win_store) begin
        if (active) begin
          wlo_q[lptr_q] <= (lo_v < 0) ? '0 : WW'(lo_v);
          whi_q[lptr_q] <= (hi_v > wmax_v) ? WW'(w_eff) - WW'(1) : WW'(hi_v);
        end else begin
          wlo_q[lptr_q] <= WW'(1); whi_q[lptr_q] <= '0;
        end
        lcnt_q <= lcnt_q + LW'(1);
        lptr_q <= lptr_n;
      end
      if (cmd_in_i.pix_rd) begin
        wptr_q <= '0; wcnt_q <= '0; wt_q <= '0;
      end
      if (cmd_in_i.wt_step && wcnt_q < n_lines) begin
        if (wlo_q[wptr_q] <= colv && colv <= whi_q[wptr_q]) wt_q <= wt_q + LW'(1);
        wcnt_q <= wcnt_q + LW'(1);
        if (32'(wcnt_q) < MaxLines - 1) wptr_q <= wptr_q + LA'(1);
      end
      if (cmd_in_i.pix_acc) begin
        if (row_end) begin
          dsum_q <= '0; wsum_q <= '0; col_q <= '0; row_q <= row_q + HW'(1);
        end else begin
          col_q <= col_q + CW'(1);
          if (row_q != '0) begin
            dsum_q <= dsum_n; wsum_q <= wsum_n;
          end
        end
      end
      if (cmd_in_i.mean_add) begin
        corr_q <= (csum > 49'(SatMax)) ? SatMax :
                  (csum < 49'(SatMin)) ? SatMin : 48'(csum);
      end
      if (cmd_in_i.out_load) begin
        m_tvalid_o <= 1'b1;
        m_value_o <= osat;
        m_last_o <= drain_ok && (drn_q >= w_eff - CW'(1));
      end else if (m_tvalid_o && m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end
      if (cmd_in_i.drain_emit) begin
        if (drn_q >= w_eff - CW'(1)) begin
          drn_q <= '0; row_q <= '0; col_q <= '0; corr_q <= '0;
          dsum_q <= '0; wsum_q <= '0;
        end else begin
          drn_q <= drn_q + CW'(1);
        end
      end
    end
  end

  assign sts_o.pix_ok     = pix_ok;
  assign sts_o.drain_ok   = drain_ok;
  assign sts_o.need_win   = col_q == '0 && row_q != '0;
  assign sts_o.has_result = row_q != '0;
  assign sts_o.row_end    = row_end;
  assign sts_o.need_mean  = row_end && row_q != '0 && wsum_n != '0;
  assign sts_o.win_done   = 32'(lcnt_q) >= MaxLines;
  assign sts_o.win_active = active;
  assign sts_o.div_done   = dcnt_q == '0;
  assign sts_o.wt_done    = wcnt_q >= n_lines;
  assign sts_o.out_busy   = m_tvalid_o && !m_tready_i;

  `PGRL_ASSERT(a_div_busy, clk_i, rst_ni,
               cmd_in_i.win_start |-> !cmd_in_i.mean_start, "divider double start")
  `PGRL_ASSERT(a_out_hold, clk_i, rst_ni,
               (m_tvalid_o && !m_tready_i) |=> $stable(m_value_o), "result changed")
  `PGRL_ASSERT(a_wt_range, clk_i, rst_ni, wcnt_q <= LW'(MaxLines), "weight scan overrun")
  `PGRL_ASSERT(a_last_drain, clk_i, rst_ni,
               (cmd_in_i.out_load && !drain_ok) |=> !m_last_o, "last on pixel")
endmodule
